@@ rtl/core/tetra_surface_point_sampler_defines.svh @@
// Assertion macros for the tetrahedron surface sampler.
`ifndef TETRA_SURFACE_POINT_SAMPLER_DEFINES_SVH
`define TETRA_SURFACE_POINT_SAMPLER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TSPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define TSPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/tsps_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tsps_pkg;

    localparam int COORD_BITS = 21;
    localparam int RAND_BITS  = 16;
    localparam int NUM_VERT   = 4;
    localparam int VERT_BITS  = 63;
    // sum of four face magnitudes, each below 2^44
    localparam int CUM_BITS   = 46;

    typedef logic [VERT_BITS-1:0]         vertex_t;
    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [CUM_BITS-1:0]          cum_t;

    // control into the area unit
    typedef struct packed {
        logic start;
    } area_ctl_t;

    // status out of the area unit
    typedef struct packed {
        logic busy;
    } area_stat_t;

    // coordinate of one axis from a packed vertex (x low, y mid, z high)
    function automatic coord_t vtx_coord(input vertex_t v, input logic [1:0] axis);
        coord_t c;
        unique case (axis)
            2'd0:    c = v[COORD_BITS-1:0];
            2'd1:    c = v[2*COORD_BITS-1:COORD_BITS];
            2'd2:    c = v[3*COORD_BITS-1:2*COORD_BITS];
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/tsps_area.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Face area sequencer: one shared 24x24 multiplier, then a radix-4 square root.
// Produces cumulative magnitudes S0..S3 of the four faces.
module tsps_area
    import tsps_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire area_ctl_t  ctl,
    input  wire vertex_t    vert [NUM_VERT],
    output area_stat_t      stat,
    output cum_t            cum  [NUM_VERT]
);

    typedef enum logic [1:0] {PH_IDLE, PH_CROSS, PH_SQUARE, PH_ROOT} phase_t;

    localparam logic [5:0] CROSS_LAST  = 6'd5;
    localparam logic [5:0] SQUARE_LAST = 6'd8;
    localparam logic [5:0] ROOT_LAST   = 6'd43;

    phase_t            phase_reg;
    logic [1:0]        face_reg;
    logic [5:0]        step_reg;
    logic signed [44:0] acc_reg;
    logic [43:0]       mag_reg [3];
    logic [87:0]       sum_reg;
    logic [47:0]       rem_reg;
    logic [43:0]       root_reg;
    cum_t              run_reg;
    cum_t              cum_reg [NUM_VERT];

    vertex_t va, vb, vc;
    logic signed [21:0] e1 [3];
    logic signed [21:0] e2 [3];
    logic signed [23:0] mul_a, mul_b;
    logic signed [47:0] prod;
    logic signed [44:0] diff;
    logic [43:0]        diff_mag;
    logic [1:0]         sq_axis;
    logic [1:0]         sq_part;
    logic [87:0]        sq_term;
    logic [47:0]        rem_next;
    logic [47:0]        trial;
    logic [43:0]        root_next;
    logic [47:0]        rem_after;
    cum_t               run_next;

    // vertices of the current face: k, k+1, k+2 mod 4
    always_comb begin
        unique case (face_reg)
            2'd0: begin va = vert[0]; vb = vert[1]; vc = vert[2]; end
            2'd1: begin va = vert[1]; vb = vert[2]; vc = vert[3]; end
            2'd2: begin va = vert[2]; vb = vert[3]; vc = vert[0]; end
            default: begin va = vert[3]; vb = vert[0]; vc = vert[1]; end
        endcase
    end

    // edge vectors
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            e1[a] = 22'(vtx_coord(vb, 2'(a))) - 22'(vtx_coord(va, 2'(a)));
            e2[a] = 22'(vtx_coord(vc, 2'(a))) - 22'(vtx_coord(va, 2'(a)));
        end
    end

    // square step decode: axis and partial product
    always_comb begin
        unique case (step_reg[3:0])
            4'd0:    begin sq_axis = 2'd0; sq_part = 2'd0; end
            4'd1:    begin sq_axis = 2'd0; sq_part = 2'd1; end
            4'd2:    begin sq_axis = 2'd0; sq_part = 2'd2; end
            4'd3:    begin sq_axis = 2'd1; sq_part = 2'd0; end
            4'd4:    begin sq_axis = 2'd1; sq_part = 2'd1; end
            4'd5:    begin sq_axis = 2'd1; sq_part = 2'd2; end
            4'd6:    begin sq_axis = 2'd2; sq_part = 2'd0; end
            4'd7:    begin sq_axis = 2'd2; sq_part = 2'd1; end
            default: begin sq_axis = 2'd2; sq_part = 2'd2; end
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (phase_reg == PH_CROSS) begin
            unique case (step_reg[2:0])
                3'd0:    begin mul_a = 24'(e1[1]); mul_b = 24'(e2[2]); end
                3'd1:    begin mul_a = 24'(e1[2]); mul_b = 24'(e2[1]); end
                3'd2:    begin mul_a = 24'(e1[2]); mul_b = 24'(e2[0]); end
                3'd3:    begin mul_a = 24'(e1[0]); mul_b = 24'(e2[2]); end
                3'd4:    begin mul_a = 24'(e1[0]); mul_b = 24'(e2[1]); end
                3'd5:    begin mul_a = 24'(e1[1]); mul_b = 24'(e2[0]); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end else begin
            // magnitude split as h*2^22 + l
            unique case (sq_part)
                2'd0: begin
                    mul_a = $signed({2'b00, mag_reg[sq_axis][43:22]});
                    mul_b = $signed({2'b00, mag_reg[sq_axis][43:22]});
                end
                2'd1: begin
                    mul_a = $signed({2'b00, mag_reg[sq_axis][43:22]});
                    mul_b = $signed({2'b00, mag_reg[sq_axis][21:0]});
                end
                default: begin
                    mul_a = $signed({2'b00, mag_reg[sq_axis][21:0]});
                    mul_b = $signed({2'b00, mag_reg[sq_axis][21:0]});
                end
            endcase
        end
    end

    assign prod     = mul_a * mul_b;
    assign diff     = acc_reg - prod[44:0];
    assign diff_mag = diff[44] ? 44'(-diff) : diff[43:0];

    // h^2 << 44, 2hl << 22, l^2
    always_comb begin
        unique case (sq_part)
            2'd0:    sq_term = {prod[43:0], 44'd0};
            2'd1:    sq_term = {21'd0, prod[43:0], 23'd0};
            default: sq_term = {44'd0, prod[43:0]};
        endcase
    end

    // one radix-4 digit of the integer square root
    assign rem_next  = {rem_reg[45:0], sum_reg[87:86]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign root_next = {root_reg[42:0], (rem_next >= trial)};
    assign rem_after = (rem_next >= trial) ? rem_next - trial : rem_next;
    assign run_next  = run_reg + CUM_BITS'(root_next);

    // sequencer and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.start) begin
            phase_reg <= PH_CROSS;
            face_reg  <= '0;
            step_reg  <= '0;
            run_reg   <= '0;
        end else begin
            unique case (phase_reg)
                PH_IDLE: begin
                end
                PH_CROSS: begin
                    if (!step_reg[0]) begin
                        acc_reg <= prod[44:0];
                    end else begin
                        mag_reg[step_reg[2:1]] <= diff_mag;
                    end
                    if (step_reg == CROSS_LAST) begin
                        phase_reg <= PH_SQUARE;
                        step_reg  <= '0;
                        sum_reg   <= '0;
                    end else begin
                        step_reg <= step_reg + 6'd1;
                    end
                end
                PH_SQUARE: begin
                    sum_reg <= sum_reg + sq_term;
                    if (step_reg == SQUARE_LAST) begin
                        phase_reg <= PH_ROOT;
                        step_reg  <= '0;
                        rem_reg   <= '0;
                        root_reg  <= '0;
                    end else begin
                        step_reg <= step_reg + 6'd1;
                    end
                end
                PH_ROOT: begin
                    sum_reg  <= {sum_reg[85:0], 2'b00};
                    rem_reg  <= rem_after;
                    root_reg <= root_next;
                    if (step_reg == ROOT_LAST) begin
                        cum_reg[face_reg] <= run_next;
                        run_reg           <= run_next;
                        step_reg          <= '0;
                        if (face_reg == 2'd3) begin
                            phase_reg <= PH_IDLE;
                        end else begin
                            phase_reg <= PH_CROSS;
                            face_reg  <= face_reg + 2'd1;
                        end
                    end else begin
                        step_reg <= step_reg + 6'd1;
                    end
                end
                default: phase_reg <= PH_IDLE;
            endcase
        end
    end

    assign stat.busy = (phase_reg != PH_IDLE);
    assign cum       = cum_reg;

endmodule

`default_nettype wire

@@ rtl/core/tetra_surface_point_sampler.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Throughput one item per cycle, unless m_tready stalls the output or an area pass runs.
// Four register stages: reflect and area product, face compare, vertex blend products, sum.
// Reset (aresetn low, synchronous) clears the vertices and all valid bits; the face area
// pass then runs with s_tready low, and runs again after every vertex write.
// The area pass is a shared 24x24 multiplier plus a 2-bit-per-cycle square root.

module tetra_surface_point_sampler
    import tsps_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // face_pick[15:0], weight_u[31:16], weight_v[47:32]
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [71:0] m_tdata    // point_x[20:0], point_y[41:21], point_z[62:42],
                                        // chosen_face[64:63], zero pad above
);

    localparam int            PROD_BITS = COORD_BITS + RAND_BITS + 2;
    localparam int            SUM_BITS  = PROD_BITS + 1;
    localparam int            SEL_BITS  = CUM_BITS + RAND_BITS;
    localparam logic [RAND_BITS:0] ONE  = (RAND_BITS+1)'(1) << RAND_BITS;

    // register map
    localparam logic [1:0] REG_VERTEX_ZERO  = 2'd0;
    localparam logic [1:0] REG_VERTEX_ONE   = 2'd1;
    localparam logic [1:0] REG_VERTEX_TWO   = 2'd2;
    localparam logic [1:0] REG_VERTEX_THREE = 2'd3;

    vertex_t    vert_reg [NUM_VERT];
    logic       cfg_wr;
    logic       addr_ok;
    area_ctl_t  area_ctl;
    area_stat_t area_stat;
    cum_t       cum [NUM_VERT];

    // configuration port
    assign pready  = 1'b1;
    assign addr_ok = (paddr[2:0] == 3'b000);
    assign cfg_wr  = psel && penable && pwrite && pready && addr_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_VERT; i++) vert_reg[i] <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[4:3])
                REG_VERTEX_ZERO:  vert_reg[0] <= pwdata[VERT_BITS-1:0];
                REG_VERTEX_ONE:   vert_reg[1] <= pwdata[VERT_BITS-1:0];
                REG_VERTEX_TWO:   vert_reg[2] <= pwdata[VERT_BITS-1:0];
                REG_VERTEX_THREE: vert_reg[3] <= pwdata[VERT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        if (addr_ok) begin
            unique case (paddr[4:3])
                REG_VERTEX_ZERO:  prdata = {1'b0, vert_reg[0]};
                REG_VERTEX_ONE:   prdata = {1'b0, vert_reg[1]};
                REG_VERTEX_TWO:   prdata = {1'b0, vert_reg[2]};
                REG_VERTEX_THREE: prdata = {1'b0, vert_reg[3]};
                default:          prdata = '0;
            endcase
        end
    end

    // face area pass, restarted by every vertex write
    assign area_ctl.start = cfg_wr;

    tsps_area u_area (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (area_ctl),
        .vert    (vert_reg),
        .stat    (area_stat),
        .cum     (cum)
    );

    // stage valids and per-stage advance
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    assign en4      = !v4_reg || m_tready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1 && !area_stat.busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_tvalid && s_tready;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // stage 1: reflection and total-area product
    logic [RAND_BITS-1:0] in_f, in_u, in_v;
    logic [RAND_BITS:0]   uv_sum;
    logic                 reflect;
    logic [RAND_BITS:0]   u_next, v_next;

    logic [SEL_BITS-1:0]  sel1_reg;
    logic [RAND_BITS:0]   u1_reg, v1w_reg, w1_reg;

    assign in_f    = s_tdata[RAND_BITS-1:0];
    assign in_u    = s_tdata[16+RAND_BITS-1:16];
    assign in_v    = s_tdata[32+RAND_BITS-1:32];
    assign uv_sum  = (RAND_BITS+1)'(in_u) + (RAND_BITS+1)'(in_v);
    assign reflect = (uv_sum > ONE);
    assign u_next  = reflect ? ONE - (RAND_BITS+1)'(in_u) : (RAND_BITS+1)'(in_u);
    assign v_next  = reflect ? ONE - (RAND_BITS+1)'(in_v) : (RAND_BITS+1)'(in_v);

    always_ff @(posedge aclk) begin
        if (en1) begin
            sel1_reg <= SEL_BITS'(cum[3]) * SEL_BITS'(in_f);
            u1_reg   <= u_next;
            v1w_reg  <= v_next;
            w1_reg   <= ONE - u_next - v_next;
        end
    end

    // stage 2: face choice, lower face wins ties
    logic [1:0]         face2_next;
    logic [1:0]         face2_reg;
    logic [RAND_BITS:0] u2_reg, v2w_reg, w2_reg;

    always_comb begin
        priority if (sel1_reg <= {cum[0], RAND_BITS'(0)}) face2_next = 2'd0;
        else if     (sel1_reg <= {cum[1], RAND_BITS'(0)}) face2_next = 2'd1;
        else if     (sel1_reg <= {cum[2], RAND_BITS'(0)}) face2_next = 2'd2;
        else                                               face2_next = 2'd3;
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            face2_reg <= face2_next;
            u2_reg    <= u1_reg;
            v2w_reg   <= v1w_reg;
            w2_reg    <= w1_reg;
        end
    end

    // stage 3: vertex select and blend products
    vertex_t va, vb, vc;
    logic signed [PROD_BITS-1:0] pw3_reg [3];
    logic signed [PROD_BITS-1:0] pu3_reg [3];
    logic signed [PROD_BITS-1:0] pv3_reg [3];
    logic [1:0]                  face3_reg;

    always_comb begin
        unique case (face2_reg)
            2'd0: begin va = vert_reg[0]; vb = vert_reg[1]; vc = vert_reg[2]; end
            2'd1: begin va = vert_reg[1]; vb = vert_reg[2]; vc = vert_reg[3]; end
            2'd2: begin va = vert_reg[2]; vb = vert_reg[3]; vc = vert_reg[0]; end
            default: begin va = vert_reg[3]; vb = vert_reg[0]; vc = vert_reg[1]; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            face3_reg <= face2_reg;
            for (int a = 0; a < 3; a++) begin
                pw3_reg[a] <= PROD_BITS'($signed({1'b0, w2_reg}) * vtx_coord(va, 2'(a)));
                pu3_reg[a] <= PROD_BITS'($signed({1'b0, u2_reg}) * vtx_coord(vb, 2'(a)));
                pv3_reg[a] <= PROD_BITS'($signed({1'b0, v2w_reg}) * vtx_coord(vc, 2'(a)));
            end
        end
    end

    // stage 4: sum and divide by 2^RAND_BITS, truncated toward zero
    logic signed [SUM_BITS-1:0] blend [3];
    logic [SUM_BITS-1:0]        blend_mag [3];
    logic [SUM_BITS-1:0]        blend_shr [3];
    coord_t                     pt_next [3];
    coord_t                     pt4_reg [3];
    logic [1:0]                 face4_reg;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            blend[a]     = SUM_BITS'(pw3_reg[a]) + SUM_BITS'(pu3_reg[a])
                         + SUM_BITS'(pv3_reg[a]);
            blend_mag[a] = blend[a][SUM_BITS-1] ? SUM_BITS'(-blend[a]) : blend[a];
            blend_shr[a] = blend_mag[a] >> RAND_BITS;
            pt_next[a]   = blend[a][SUM_BITS-1] ? COORD_BITS'(-blend_shr[a])
                                                : blend_shr[a][COORD_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            face4_reg <= face3_reg;
            for (int a = 0; a < 3; a++) pt4_reg[a] <= pt_next[a];
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {7'd0, face4_reg, pt4_reg[2], pt4_reg[1], pt4_reg[0]};

    // checks
`include "tetra_surface_point_sampler_defines.svh"

    `TSPS_ASSERT_NOW(a_no_take_while_busy, area_stat.busy, !s_tready, "input taken during area pass")
    `TSPS_ASSERT_NEXT(a_write_restarts_area, cfg_wr, area_stat.busy, "vertex write did not restart area pass")
    `TSPS_ASSERT_NEXT(a_transfer_enters_pipe, s_tvalid && s_tready, v1_reg, "accepted item lost at stage one")

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import tsps_pkg::*;

    typedef struct {
        logic signed [COORD_BITS-1:0] x, y, z;
        logic [1:0]                   face;
    } surf_point_t;

    typedef struct {
        logic [15:0] f, u, v;
        bit          typed;
        surf_point_t pt;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;

    vertex_t     vert_cfg [NUM_VERT];
    surf_point_t point_q [$];
    int          fails = 0;
    int          hold_left = 0;
    int          long_hold = 0;
    bit          quiet = 1'b0;

    tetra_surface_point_sampler uut (.*);

    always #5 aclk = ~aclk;

    initial begin
        #20ms;
        $display("tetra_surface_point_sampler test failed");
        $finish;
    end

    function automatic longint crd(int vi, int axis);
        logic signed [COORD_BITS-1:0] c;
        c = vert_cfg[vi & 3][axis*COORD_BITS +: COORD_BITS];
        return longint'(c);
    endfunction

    // doubled face area: floor(sqrt(|e1 x e2|^2))
    function automatic logic [63:0] face_mag(int k);
        longint      e1 [3], e2 [3], c [3];
        logic [127:0] acc, m, t;
        logic [63:0] r;
        acc = '0;
        r = '0;
        for (int a = 0; a < 3; a++) begin
            e1[a] = crd(k + 1, a) - crd(k, a);
            e2[a] = crd(k + 2, a) - crd(k, a);
        end
        c[0] = e1[1] * e2[2] - e1[2] * e2[1];
        c[1] = e1[2] * e2[0] - e1[0] * e2[2];
        c[2] = e1[0] * e2[1] - e1[1] * e2[0];
        for (int a = 0; a < 3; a++) begin
            m = (c[a] < 0) ? 128'(-c[a]) : 128'(c[a]);
            acc += m * m;
        end
        for (int b = 47; b >= 0; b--) begin
            t = 128'(r | (64'd1 << b));
            if (t * t <= acc) r = t[63:0];
        end
        return r;
    endfunction

    function automatic surf_point_t sample_point(logic [15:0] f, logic [15:0] u0,
                                                 logic [15:0] v0);
        logic [127:0] cum [4];
        logic [127:0] sel;
        longint       u, v, w, s, m;
        int           k;
        surf_point_t  p;
        for (int i = 0; i < 4; i++)
            cum[i] = 128'(face_mag(i)) + ((i > 0) ? cum[i-1] : 128'd0);
        sel = cum[3] * 128'(f);
        k = 3;
        for (int i = 2; i >= 0; i--)
            if (sel <= (cum[i] << RAND_BITS)) k = i;
        u = u0;
        v = v0;
        if (u + v > 65536) begin
            u = 65536 - u;
            v = 65536 - v;
        end
        w = 65536 - u - v;
        for (int a = 0; a < 3; a++) begin
            s = w * crd(k, a) + u * crd(k + 1, a) + v * crd(k + 2, a);
            m = ((s < 0) ? -s : s) >>> RAND_BITS;
            if (s < 0) m = -m;
            case (a)
                0: p.x = m[COORD_BITS-1:0];
                1: p.y = m[COORD_BITS-1:0];
                default: p.z = m[COORD_BITS-1:0];
            endcase
        end
        p.face = k[1:0];
        return p;
    endfunction

    function automatic vertex_t vpack(int x, int y, int z);
        logic [COORD_BITS-1:0] cx, cy, cz;
        cx = x[COORD_BITS-1:0];
        cy = y[COORD_BITS-1:0];
        cz = z[COORD_BITS-1:0];
        return {cz, cy, cx};
    endfunction

    function automatic int ext_coord();
        return $urandom_range(0, 1) ? 1048575 : -1048576;
    endfunction

    // predict on input transfer, check on result transfer
    always @(posedge aclk) begin
        surf_point_t exp_pt, got;
        if (aresetn && s_tvalid && s_tready)
            point_q.push_back(sample_point(s_tdata[15:0], s_tdata[31:16], s_tdata[47:32]));
        if (aresetn && m_tvalid && m_tready) begin
            got.x = m_tdata[20:0];
            got.y = m_tdata[41:21];
            got.z = m_tdata[62:42];
            got.face = m_tdata[64:63];
            if (point_q.size() == 0) begin
                $error("result transfer with nothing expected");
                fails++;
            end else begin
                exp_pt = point_q.pop_front();
                if (got.x !== exp_pt.x) begin
                    $error("point_x expected %0d got %0d", exp_pt.x, got.x); fails++;
                end
                if (got.y !== exp_pt.y) begin
                    $error("point_y expected %0d got %0d", exp_pt.y, got.y); fails++;
                end
                if (got.z !== exp_pt.z) begin
                    $error("point_z expected %0d got %0d", exp_pt.z, got.z); fails++;
                end
                if (got.face !== exp_pt.face) begin
                    $error("chosen_face expected %0d got %0d", exp_pt.face, got.face);
                    fails++;
                end
            end
        end
    end

    // receiver: short random stalls, one long hold-off on request
    always @(posedge aclk) begin
        if (long_hold > 0) begin
            m_tready <= 1'b0;
            long_hold--;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            hold_left = $urandom_range(0, 3);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic apb_write(int idx, logic [63:0] val);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 5'(idx * 8); pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        vert_cfg[idx] = val[62:0];
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic wait_drained();
        while (point_q.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic load_solid(vertex_t a, vertex_t b, vertex_t c, vertex_t d);
        apb_write(0, {$urandom_range(0, 1) ? 1'b1 : 1'b0, a});
        apb_write(1, {1'b0, b});
        apb_write(2, {1'b1, c});
        apb_write(3, {1'b0, d});
    endtask

    // one input transfer, then maybe a short gap
    task automatic send_sample(logic [15:0] f, logic [15:0] u, logic [15:0] v);
        s_tvalid <= 1'b1;
        s_tdata <= {v, u, f};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    function automatic logic [15:0] rand_frac();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        stim_row_t rows [$];
        surf_point_t zero_pt, v0_pt;
        surf_point_t got_exp;
        int n_zero;
        zero_pt = '{x: '0, y: '0, z: '0, face: 2'd0};
        v0_pt = '{x: 21'sd1024, y: 21'sd1024, z: 21'sd1024, face: 2'd0};
        for (int i = 0; i < 4; i++) vert_cfg[i] = '0;

        // degenerate solid after reset: everything collapses to origin on face 0
        rows.push_back('{16'h0000, 16'h0000, 16'h0000, 1'b1, zero_pt});
        rows.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, zero_pt});
        rows.push_back('{16'h8000, 16'h8000, 16'h8000, 1'b1, zero_pt});
        rows.push_back('{16'hC000, 16'h1234, 16'hFEDC, 1'b1, zero_pt});
        n_zero = rows.size();
        // equal-area solid: ties at quarter points, reflection edges
        rows.push_back('{16'h0000, 16'h0000, 16'h0000, 1'b1, v0_pt});
        rows.push_back('{16'h4000, 16'h1000, 16'h2000, 1'b0, zero_pt});
        rows.push_back('{16'h4001, 16'h1000, 16'h2000, 1'b0, zero_pt});
        rows.push_back('{16'h8000, 16'h4000, 16'h3000, 1'b0, zero_pt});
        rows.push_back('{16'h8001, 16'h0001, 16'hFFFF, 1'b0, zero_pt});
        rows.push_back('{16'hC000, 16'h8000, 16'h8000, 1'b0, zero_pt});
        rows.push_back('{16'hC001, 16'h8000, 16'h8001, 1'b0, zero_pt});
        rows.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, zero_pt});
        rows.push_back('{16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, zero_pt});
        rows.push_back('{16'h3FFF, 16'h0000, 16'hFFFF, 1'b0, zero_pt});
        rows.push_back('{16'hBFFF, 16'hAAAA, 16'h5555, 1'b0, zero_pt});
        rows.push_back('{16'h7FFF, 16'h5556, 16'hAAAA, 1'b0, zero_pt});

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed rows; typed ones are cross-checked against the predictor
        foreach (rows[i]) begin
            if (i == n_zero) begin
                s_tvalid <= 1'b0;
                wait_drained();
                load_solid(vpack(1024, 1024, 1024), vpack(1024, -1024, -1024),
                           vpack(-1024, 1024, -1024), vpack(-1024, -1024, 1024));
            end
            if (rows[i].typed) begin
                got_exp = sample_point(rows[i].f, rows[i].u, rows[i].v);
                if (got_exp.x !== rows[i].pt.x || got_exp.y !== rows[i].pt.y ||
                    got_exp.z !== rows[i].pt.z || got_exp.face !== rows[i].pt.face) begin
                    $error("directed row %0d: predictor disagrees with table", i);
                    fails++;
                end
            end
            send_sample(rows[i].f, rows[i].u, rows[i].v);
        end

        // random solids, extremes among them
        for (int ph = 0; ph < 8; ph++) begin
            s_tvalid <= 1'b0;
            wait_drained();
            case (ph)
                0: load_solid(vpack(ext_coord(), ext_coord(), ext_coord()),
                              vpack(ext_coord(), ext_coord(), ext_coord()),
                              vpack(ext_coord(), ext_coord(), ext_coord()),
                              vpack(ext_coord(), ext_coord(), ext_coord()));
                1: load_solid(vpack(-1048576, -1048576, -1048576),
                              vpack(1048575, -1048576, -1048576),
                              vpack(-1048576, 1048575, -1048576),
                              vpack(-1048576, -1048576, 1048575));
                2: load_solid(vpack(5, 5, 5), vpack(5, 5, 5), vpack(5, 5, 5),
                              vpack(9, -3, 7));
                default: load_solid(vertex_t'({$urandom, $urandom}),
                                    vertex_t'({$urandom, $urandom}),
                                    vertex_t'({$urandom, $urandom}),
                                    vertex_t'({$urandom, $urandom}));
            endcase
            if (ph == 3) long_hold = 300;
            if (ph == 7) quiet = 1'b1;
            for (int n = 0; n < 235; n++)
                send_sample(rand_frac(), rand_frac(), rand_frac());
        end
        s_tvalid <= 1'b0;

        while (point_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fails == 0)
            $display("tetra_surface_point_sampler test passed");
        else
            $display("tetra_surface_point_sampler test failed");
        $finish;
    end

endmodule
